// ----- rtl/core/lcd_line_timing_and_bg_render_top_macros.svh -----
// Assertion helpers for the RTL.
`ifndef LCD_LINE_TIMING_AND_BG_RENDER_TOP_MACROS_SVH
`define LCD_LINE_TIMING_AND_BG_RENDER_TOP_MACROS_SVH

// Check that expr holds at every edge outside reset.
`define LBR_CHECK(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("lbr invariant violated");

// Check that post holds in the cycle where pre holds.
`define LBR_CHECK_IMP(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("lbr implication violated");

// Check that post holds in the cycle after pre.
`define LBR_CHECK_NXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lbr sequence violated");

`endif

// ----- rtl/core/lbr_pkg.sv -----
`timescale 1ns / 1ps
package lbr_pkg;

   localparam int VRAM_BYTES = 8192;
   localparam int VRAM_HALF  = VRAM_BYTES / 2;

   localparam int          OAM_DOTS          = 80;
   localparam logic [7:0]  FIRST_VBLANK_LINE = 8'd144;
   localparam logic [7:0]  LAST_LINE         = 8'd153;

   // status source bits, same order as the enable register
   localparam int SRC_HBLANK = 0;
   localparam int SRC_VBLANK = 1;
   localparam int SRC_OAM    = 2;
   localparam int SRC_MATCH  = 3;

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_XFER   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CSR_LCD_ENABLE   = 3'd0,
      CSR_BG_MAP_SEL   = 3'd1,
      CSR_TILE_DATA    = 3'd2,
      CSR_SCROLL_X     = 3'd3,
      CSR_SCROLL_Y     = 3'd4,
      CSR_LINE_COMPARE = 3'd5,
      CSR_BG_PALETTE   = 3'd6,
      CSR_STAT_ENABLE  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic       lcd_enable;
      logic       bg_map_select;
      logic       tile_data_select;
      logic [7:0] scroll_x;
      logic [7:0] scroll_y;
      logic [7:0] line_compare;
      logic [7:0] bg_palette;
      logic [3:0] stat_enable;
   } cfg_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] line;
      logic       coincidence;
      logic       vblank_irq;
      logic       stat_irq;
      logic       pixel_valid;
      logic [7:0] pixel_x;
      logic [1:0] pixel_0;
      logic [1:0] pixel_1;
      logic [1:0] pixel_2;
      logic [1:0] pixel_3;
   } result_type;

   function automatic logic [1:0] bg_shade(input logic [7:0] pal, input logic [7:0] lo,
                                           input logic [7:0] hi, input logic [2:0] bitpos);
      logic [1:0] id;
      id = {hi[bitpos], lo[bitpos]};
      case (id)
         2'd0:    return pal[1:0];
         2'd1:    return pal[3:2];
         2'd2:    return pal[5:4];
         default: return pal[7:6];
      endcase
   endfunction

endpackage

// ----- rtl/core/lbr_ifs.sv -----
`timescale 1ns / 1ps
interface lbr_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [12:0] vram_address;
   logic [7:0]  vram_data;
   modport source (output valid, command, vram_address, vram_data, input ready);
   modport sink   (input valid, command, vram_address, vram_data, output ready);
endinterface

interface lbr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] line;
   logic       coincidence;
   logic       vblank_irq;
   logic       stat_irq;
   logic       pixel_valid;
   logic [7:0] pixel_x;
   logic [1:0] pixel_0;
   logic [1:0] pixel_1;
   logic [1:0] pixel_2;
   logic [1:0] pixel_3;
   modport source (output valid, mode, line, coincidence, vblank_irq, stat_irq, pixel_valid,
                   pixel_x, pixel_0, pixel_1, pixel_2, pixel_3, input ready);
   modport sink   (input valid, mode, line, coincidence, vblank_irq, stat_irq, pixel_valid,
                   pixel_x, pixel_0, pixel_1, pixel_2, pixel_3, output ready);
endinterface

interface lbr_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/lcd_line_timing_and_bg_render_top.sv -----
`timescale 1ns / 1ps
// LCD line timing and background renderer.
// req_ch carries one beat per command: command 1 stores vram_data at vram_address in the
// 8 KiB video memory and gives no result; command 0 advances the controller by
// DOTS_PER_TICK dots and gives exactly one rsp_ch beat (mode, line, coincidence, irq
// pulses and up to four background pixel shades).
// csr_ch writes one of the eight control registers per beat and is always ready;
// write registers only while no advance is in flight.
// Results: a plain advance result goes straight into the result register when its beat is taken. An advance
// that loads a new tile row (end of OAM search, or an 8-pixel boundary during transfer)
// runs a map entry read, then a tile row read, from one synchronous memory
// port split into even and odd byte banks, and then loads the result register.
// Throughput: one beat per cycle for writes and plain advances while the result register
// drains; an advance that fetches a tile row holds req_ch.ready low until it is done.
// Reset: timing state and registers go to zero; video memory is not cleared and must be
// written before it is displayed.
// Stall: the result register holds while rsp_ch.ready is low; a new beat is still taken
// when the result register is drained in the same cycle, otherwise req_ch.ready drops.
module lcd_line_timing_and_bg_render_top #(
   parameter int SCREEN_WIDTH  = 160,
   parameter int LINE_DOTS     = 456,
   parameter int DOTS_PER_TICK = 4
) (
   input logic      clock,
   input logic      reset,
   lbr_req_if.sink  req_ch,
   lbr_rsp_if.source rsp_ch,
   lbr_csr_if.sink  csr_ch
);
   import lbr_pkg::*;

   cfg_type    cfg_ff;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       busy;
   logic       res_valid;
   result_type res;
   logic       in_fire;

   // take a beat only when the engine is free and the result slot is free or draining
   assign req_ch.ready = !busy && (!rsp_valid_ff || rsp_ch.ready);
   assign in_fire      = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   lbr_engine #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .LINE_DOTS    (LINE_DOTS),
      .DOTS_PER_TICK(DOTS_PER_TICK)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .in_fire        (in_fire),
      .in_command     (req_ch.command),
      .in_vram_address(req_ch.vram_address),
      .in_vram_data   (req_ch.vram_data),
      .in_busy        (busy),
      .res_valid      (res_valid),
      .res            (res)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_LCD_ENABLE:   cfg_ff.lcd_enable       <= csr_ch.data[0];
            CSR_BG_MAP_SEL:   cfg_ff.bg_map_select    <= csr_ch.data[0];
            CSR_TILE_DATA:    cfg_ff.tile_data_select <= csr_ch.data[0];
            CSR_SCROLL_X:     cfg_ff.scroll_x         <= csr_ch.data;
            CSR_SCROLL_Y:     cfg_ff.scroll_y         <= csr_ch.data;
            CSR_LINE_COMPARE: cfg_ff.line_compare     <= csr_ch.data;
            CSR_BG_PALETTE:   cfg_ff.bg_palette       <= csr_ch.data;
            CSR_STAT_ENABLE:  cfg_ff.stat_enable      <= csr_ch.data[3:0];
            default:          cfg_ff <= cfg_ff;
         endcase
      end
   end

   // result register: load a new beat, else drop the old one once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_valid) rsp_ff <= res;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.mode        = rsp_ff.mode;
   assign rsp_ch.line        = rsp_ff.line;
   assign rsp_ch.coincidence = rsp_ff.coincidence;
   assign rsp_ch.vblank_irq  = rsp_ff.vblank_irq;
   assign rsp_ch.stat_irq    = rsp_ff.stat_irq;
   assign rsp_ch.pixel_valid = rsp_ff.pixel_valid;
   assign rsp_ch.pixel_x     = rsp_ff.pixel_x;
   assign rsp_ch.pixel_0     = rsp_ff.pixel_0;
   assign rsp_ch.pixel_1     = rsp_ff.pixel_1;
   assign rsp_ch.pixel_2     = rsp_ff.pixel_2;
   assign rsp_ch.pixel_3     = rsp_ff.pixel_3;

endmodule

// ----- rtl/core/lbr_engine.sv -----
`timescale 1ns / 1ps
`include "lcd_line_timing_and_bg_render_top_macros.svh"
module lbr_engine #(
   parameter int SCREEN_WIDTH  = 160,
   parameter int LINE_DOTS     = 456,
   parameter int DOTS_PER_TICK = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  lbr_pkg::cfg_type    cfg,
   input  logic                in_fire,
   input  logic                in_command,
   input  logic [12:0]         in_vram_address,
   input  logic [7:0]          in_vram_data,
   output logic                in_busy,
   output logic                res_valid,
   output lbr_pkg::result_type res
);
   import lbr_pkg::*;

   localparam int DOT_W = $clog2(LINE_DOTS);
   localparam int SUM_W = DOT_W + 1;
   localparam logic [SUM_W-1:0] LINE_END = SUM_W'(LINE_DOTS);
   localparam logic [SUM_W-1:0] OAM_END  = SUM_W'(OAM_DOTS);
   localparam logic [SUM_W-1:0] TICK     = SUM_W'(DOTS_PER_TICK);
   localparam logic [8:0]       WIDTH9   = 9'(SCREEN_WIDTH);
   localparam logic [8:0]       TICK9    = 9'(DOTS_PER_TICK);
   localparam logic [2:0]       TICK3    = 3'(DOTS_PER_TICK);

   typedef enum logic [1:0] {ST_IDLE, ST_MAP, ST_TILE} state_type;

   // video memory split by address bit 0: a tile row's two bytes come in one read
   logic [7:0] mem_even [VRAM_HALF];
   logic [7:0] mem_odd  [VRAM_HALF];
   logic [7:0] rd_even_ff, rd_odd_ff;
   logic       rd_en;
   logic [11:0] rd_idx;
   logic       wr_en;

   state_type  state_ff;
   logic [1:0] mode_ff;
   logic [DOT_W-1:0] dot_ff;
   logic [7:0] line_ff, col_ff, mapx_ff, mapy_ff, tlo_ff, thi_ff;
   logic       match_ff;

   logic       map_sel_ff;
   logic [7:0] sv_mx_ff;
   logic [2:0] sv_n_ff;
   logic [3:0] sv_k_ff;
   result_type hdr_ff;

   logic [1:0] x_mode;
   logic [DOT_W-1:0] x_dot;
   logic [7:0] x_line, x_col, x_mapx, x_mapy, line_inc;
   logic       x_match, x_fetch, x_vb;
   logic [3:0] x_src;
   logic [2:0] x_n;
   logic [3:0] x_k;
   logic [SUM_W-1:0] dot_sum;
   logic [12:0] map_addr;
   logic [7:0] tile_num;
   logic       adv_fire;
   result_type res_idle;

   logic [7:0] px_mx, new_lo, new_hi;
   logic [2:0] px_n, slot_pos;
   logic [3:0] px_k;
   logic [1:0] pix [4];

   always_ff @(posedge clock) begin
      if (wr_en && !in_vram_address[0]) mem_even[in_vram_address[12:1]] <= in_vram_data;
      if (wr_en &&  in_vram_address[0]) mem_odd[in_vram_address[12:1]]  <= in_vram_data;
      if (rd_en) begin
         rd_even_ff <= mem_even[rd_idx];
         rd_odd_ff  <= mem_odd[rd_idx];
      end
   end

   assign adv_fire = in_fire && !in_command && (state_ff == ST_IDLE);
   assign wr_en    = in_fire &&  in_command && (state_ff == ST_IDLE);
   assign in_busy  = (state_ff != ST_IDLE);

   // one tick of the line timing
   always_comb begin
      x_mode  = mode_ff;
      x_dot   = dot_ff;
      x_line  = line_ff;
      x_match = match_ff;
      x_col   = col_ff;
      x_mapx  = mapx_ff;
      x_mapy  = mapy_ff;
      x_src   = '0;
      x_vb    = 1'b0;
      x_fetch = 1'b0;
      x_n     = '0;
      x_k     = 4'd8 - {1'b0, mapx_ff[2:0]};
      dot_sum = {1'b0, dot_ff} + TICK;
      line_inc = line_ff + 8'd1;
      if (cfg.lcd_enable) begin
         case (mode_ff)
            MODE_HBLANK, MODE_VBLANK: begin
               x_dot = DOT_W'(dot_sum);
               if (dot_sum >= LINE_END) begin
                  x_dot = DOT_W'(dot_sum - LINE_END);
                  if (mode_ff == MODE_HBLANK) begin
                     x_line = line_inc;
                     if (line_inc < FIRST_VBLANK_LINE) begin
                        x_mode = MODE_OAM;
                        x_src[SRC_OAM] = 1'b1;
                     end else begin
                        x_mode = MODE_VBLANK;
                        x_vb   = 1'b1;
                        x_src[SRC_VBLANK] = 1'b1;
                     end
                  end else if (line_ff >= LAST_LINE) begin
                     x_line = '0;
                     x_mode = MODE_OAM;
                     x_src[SRC_OAM] = 1'b1;
                  end else begin
                     x_line = line_inc;
                  end
                  x_match = (x_line == cfg.line_compare);
                  x_src[SRC_MATCH] = x_match;
               end
            end
            MODE_OAM: begin
               x_dot = DOT_W'(dot_sum);
               if (dot_sum >= OAM_END) begin
                  x_mode  = MODE_XFER;
                  x_col   = '0;
                  x_mapx  = cfg.scroll_x;
                  x_mapy  = cfg.scroll_y + line_ff;
                  x_fetch = 1'b1;
               end
            end
            MODE_XFER: begin
               x_dot = DOT_W'(dot_sum);
               if ({1'b0, col_ff} + TICK9 >= WIDTH9) begin
                  x_n    = 3'(WIDTH9 - {1'b0, col_ff});
                  x_col  = '0;
                  x_mode = MODE_HBLANK;
                  x_src[SRC_HBLANK] = 1'b1;
               end else begin
                  x_n   = TICK3;
                  x_col = col_ff + {5'd0, TICK3};
               end
               x_mapx  = mapx_ff + {5'd0, x_n};
               x_fetch = (x_k <= {1'b0, x_n});
            end
            default: begin
            end
         endcase
      end
      map_addr = {2'b11, cfg.bg_map_select, x_mapy[7:3], x_mapx[7:3]};

      res_idle             = '0;
      res_idle.mode        = x_mode;
      res_idle.line        = x_line;
      res_idle.coincidence = x_match;
      res_idle.vblank_irq  = x_vb;
      res_idle.stat_irq    = |(x_src & cfg.stat_enable);
      res_idle.pixel_valid = cfg.lcd_enable && (mode_ff == MODE_XFER);
      res_idle.pixel_x     = res_idle.pixel_valid ? col_ff : 8'd0;
   end

   // memory read sequencing: map entry, then the tile row pair
   always_comb begin
      tile_num = map_sel_ff ? rd_odd_ff : rd_even_ff;
      rd_en    = 1'b0;
      rd_idx   = map_addr[12:1];
      case (state_ff)
         ST_IDLE: rd_en = adv_fire && x_fetch;
         ST_MAP: begin
            rd_en  = 1'b1;
            rd_idx = {~cfg.tile_data_select & ~tile_num[7], tile_num, mapy_ff[2:0]};
         end
         default: rd_en = 1'b0;
      endcase
   end

   // pixel slots: those before the tile boundary use the old row
   always_comb begin
      if (state_ff == ST_TILE) begin
         px_mx  = sv_mx_ff;
         px_n   = sv_n_ff;
         px_k   = sv_k_ff;
         new_lo = rd_even_ff;
         new_hi = rd_odd_ff;
      end else begin
         px_mx  = mapx_ff;
         px_n   = x_n;
         px_k   = x_k;
         new_lo = tlo_ff;
         new_hi = thi_ff;
      end
      slot_pos = '0;
      for (int i = 0; i < 4; i++) begin
         pix[i]   = 2'd0;
         slot_pos = px_mx[2:0] + 3'(i);
         if (3'(i) < px_n) begin
            if (4'(i) < px_k) pix[i] = bg_shade(cfg.bg_palette, tlo_ff, thi_ff, ~slot_pos);
            else              pix[i] = bg_shade(cfg.bg_palette, new_lo, new_hi, ~slot_pos);
         end
      end
      res         = (state_ff == ST_TILE) ? hdr_ff : res_idle;
      res.pixel_0 = pix[0];
      res.pixel_1 = pix[1];
      res.pixel_2 = pix[2];
      res.pixel_3 = pix[3];
      res_valid   = (adv_fire && !x_fetch) || (state_ff == ST_TILE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_HBLANK;
         dot_ff   <= '0;
         line_ff  <= '0;
         match_ff <= 1'b0;
         col_ff   <= '0;
         mapx_ff  <= '0;
         mapy_ff  <= '0;
         tlo_ff   <= '0;
         thi_ff   <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (adv_fire) begin
                  mode_ff  <= x_mode;
                  dot_ff   <= x_dot;
                  line_ff  <= x_line;
                  match_ff <= x_match;
                  col_ff   <= x_col;
                  mapx_ff  <= x_mapx;
                  mapy_ff  <= x_mapy;
                  if (x_fetch) state_ff <= ST_MAP;
               end
            end
            ST_MAP: state_ff <= ST_TILE;
            ST_TILE: begin
               tlo_ff   <= rd_even_ff;
               thi_ff   <= rd_odd_ff;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
      if (adv_fire) begin
         map_sel_ff <= map_addr[0];
         sv_mx_ff   <= mapx_ff;
         sv_n_ff    <= x_n;
         sv_k_ff    <= x_k;
         hdr_ff     <= res_idle;
      end
   end

   `LBR_CHECK_NXT(a_map_then_tile, clock, reset, state_ff == ST_MAP, state_ff == ST_TILE)
   `LBR_CHECK(a_line_range, clock, reset, line_ff <= LAST_LINE)
   `LBR_CHECK(a_dot_range, clock, reset, {1'b0, dot_ff} < LINE_END)
   `LBR_CHECK_IMP(a_xfer_col, clock, reset, mode_ff == MODE_XFER, {1'b0, col_ff} < WIDTH9)
   `LBR_CHECK_IMP(a_vb_mode, clock, reset, res_valid && res.vblank_irq, res.mode == MODE_VBLANK)

endmodule
